@@ design/lzwvw_pkg.sv @@
// shared constants of the variable-width lzw encoder
// no dependencies
`default_nettype none
package lzwvw_pkg;
  localparam int unsigned MaxCodeBitsDefault   = 12;
  localparam int unsigned HashTableSizeDefault = 5021;
  localparam int unsigned CodeClear            = 256;
  localparam int unsigned CodeEnd              = 257;
  localparam int unsigned CodeFirst            = 258;
  localparam int unsigned WidthStart           = 9;
  localparam int unsigned RatioStart           = 100;
  localparam int unsigned IntervalReset        = 100;
endpackage
`default_nettype wire

@@ design/lzw_encoder_variable_width_top.sv @@
// variable-width lzw encoder: byte stream in, packed msb-first codes out
// depends on lzwvw_pkg
//
// usage: s_axis carries one input transaction per byte (tuser = 1 asks to finish
// the stream, tdata ignored then). m_axis carries packed code bytes; tlast
// marks the final byte caused by one input transaction, tuser the final byte
// of a finished stream. cfg_* writes check_interval; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// sequence: a byte is probed in the dictionary ram, one probe after another,
// behind the registered ram read. a matched byte ends after its hit probe; a
// missed byte passes a bookkeeping state and then, per code, a load state, one
// drain step per output byte and a closing drain step. a ratio check adds a
// bit-serial divide and a compare state. a finish sends five codes (up to 8
// bytes with the default MAX_CODE_BITS). after reset, after a finish and after
// a clear code the dictionary ram is swept one entry per cycle; s_axis_tready is
// low then. when the receiver stalls, the output register holds its byte and
// the encoder waits; nothing is dropped.
`default_nettype none
module lzw_encoder_variable_width_top #(
  parameter int unsigned MAX_CODE_BITS   = lzwvw_pkg::MaxCodeBitsDefault,
  parameter int unsigned HASH_TABLE_SIZE = lzwvw_pkg::HashTableSizeDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  wire logic       s_axis_tuser,   // mode
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte[7:0]
  output logic            m_axis_tlast,
  output logic            m_axis_tuser,   // stream_done
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned MCB = MAX_CODE_BITS;
  localparam int unsigned CW  = MCB + 1;
  localparam int unsigned IW  = $clog2(HASH_TABLE_SIZE);
  localparam int unsigned HW  = ((MCB > IW) ? MCB : IW) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RATIO = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_CLR   = 3'd7;

  typedef struct packed {
    logic           used;
    logic [MCB-1:0] code;
    logic [MCB-1:0] prefix;
    logic [7:0]     ch;
  } slot_t;

  slot_t slots [HASH_TABLE_SIZE];
  slot_t rd_q, mem_wd;
  logic  mem_we;
  logic [IW-1:0] mem_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slots[mem_addr] <= mem_wd;
    end
    rd_q <= slots[mem_addr];
  end

  logic [2:0]     state_q, state_d;
  logic [15:0]    intv_q, intv_d;
  logic [MCB-1:0] cur_q, cur_d;
  logic [CW-1:0]  nfc_q, nfc_d, lim_q, lim_d;
  logic [3:0]     cw_q, cw_d, ew_q, ew_d;
  logic [31:0]    acc_q, acc_d;
  logic [5:0]     fill_q, fill_d;
  logic [31:0]    cin_q, cin_d, cout_q, cout_d, nchk_q, nchk_d;
  logic [15:0]    prev_q, prev_d;
  logic           first_q, first_d;
  logic [7:0]     byte_q, byte_d;
  logic [IW-1:0]  idx_q, idx_d, step_q, step_d, clr_q, clr_d;
  logic [IW-1:0]  n_q, n_d;
  logic [MCB-1:0] ecode_q, ecode_d;
  logic [2:0]     ek_q, ek_d, nc_q, nc_d;
  logic           fin_q, fin_d, clrp_q, clrp_d;
  logic [31:0]    rem_q, rem_d, quo_q, quo_d;
  logic [4:0]     dcnt_q, dcnt_d;
  logic           ov_q, ov_d, ol_q, ol_d, od_q, od_d;
  logic [7:0]     ob_q, ob_d;

  logic [HW-1:0]  hash;
  logic [IW-1:0]  hidx, hstep, pnext;
  logic [IW:0]    pwide;
  logic           out_free, hit;
  logic [MCB-1:0] sel_code;
  logic [31:0]    cmask, cval, cout_new, cx100;
  logic [5:0]     nbytes, fill_after;
  logic [32:0]    trial;
  logic [3:0]     cw_up;

  always_comb begin
    hash = HW'({s_axis_tdata, (MCB - 8)'(0)}) ^ HW'(cur_q);
    for (int k = 0; k < 4; k++) begin
      if (hash >= HW'(HASH_TABLE_SIZE)) begin
        hash = hash - HW'(HASH_TABLE_SIZE);
      end
    end
    hidx  = hash[IW-1:0];
    hstep = (hidx == '0) ? IW'(1) : IW'(HASH_TABLE_SIZE - {1'b0, hidx});
  end

  always_comb begin
    if (idx_q >= step_q) begin
      pwide = {1'b0, idx_q} - {1'b0, step_q};
    end else begin
      pwide = {1'b0, idx_q} + (IW + 1)'(HASH_TABLE_SIZE) - {1'b0, step_q};
    end
    pnext = pwide[IW-1:0];
  end

  always_comb begin
    if (ek_q == 3'd0) begin
      sel_code = ecode_q;
    end else if (!fin_q) begin
      sel_code = MCB'(lzwvw_pkg::CodeClear);
    end else if (ek_q == 3'd1) begin
      sel_code = MCB'(lzwvw_pkg::CodeEnd);
    end else begin
      sel_code = '0;
    end
    cmask = (32'd1 << ew_q) - 32'd1;
    cval  = 32'(sel_code) & cmask;
  end

  assign out_free   = !ov_q || m_axis_tready;
  assign hit        = rd_q.used && (rd_q.prefix == cur_q) && (rd_q.ch == byte_q);
  assign nbytes     = (fill_q + {2'b0, cw_q}) >> 3;
  assign cout_new   = cout_q + 32'(nbytes);
  assign cx100      = (cout_new << 6) + (cout_new << 5) + (cout_new << 2);
  assign trial      = {rem_q, quo_q[31]};
  assign fill_after = fill_q - 6'd8;
  assign cw_up      = cw_q + 4'd1;

  always_comb begin
    state_d = state_q; intv_d = intv_q; cur_d = cur_q; nfc_d = nfc_q; lim_d = lim_q;
    cw_d = cw_q; ew_d = ew_q; acc_d = acc_q; fill_d = fill_q; cin_d = cin_q;
    cout_d = cout_q; nchk_d = nchk_q; prev_d = prev_q; first_d = first_q;
    byte_d = byte_q; idx_d = idx_q; step_d = step_q; clr_d = clr_q; n_d = n_q;
    ecode_d = ecode_q; ek_d = ek_q; nc_d = nc_q; fin_d = fin_q; clrp_d = clrp_q;
    rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q;
    ov_d = ov_q; ol_d = ol_q; od_d = od_q; ob_d = ob_q;
    mem_we = 1'b0; mem_addr = idx_q; mem_wd = '0;
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (cfg_valid_i) begin
      intv_d = cfg_data_i;
    end
    case (state_q)
      S_IDLE: begin
        mem_addr = hidx;
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            ecode_d = cur_q; ew_d = cw_q; fin_d = 1'b1; clrp_d = 1'b0;
            ek_d = 3'd0; nc_d = 3'd5; state_d = S_LOAD;
          end else if (first_q) begin
            cur_d = MCB'(s_axis_tdata); first_d = 1'b0;
          end else begin
            cin_d = cin_q + 32'd1; byte_d = s_axis_tdata;
            idx_d = hidx; step_d = hstep; n_d = '0; state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          cur_d = rd_q.code; state_d = S_IDLE;
        end else if (!rd_q.used || n_q == IW'(HASH_TABLE_SIZE - 1)) begin
          if (!rd_q.used && nfc_q <= lim_q) begin
            mem_we = 1'b1;
            mem_wd = '{used: 1'b1, code: nfc_q[MCB-1:0], prefix: cur_q, ch: byte_q};
            nfc_d = nfc_q + CW'(1);
          end
          ecode_d = cur_q; ew_d = cw_q; cur_d = MCB'(byte_q);
          fin_d = 1'b0; clrp_d = 1'b0; ek_d = 3'd0; nc_d = 3'd1;
          state_d = S_UPD;
        end else begin
          idx_d = pnext; mem_addr = pnext; n_d = n_q + IW'(1);
        end
      end
      S_UPD: begin
        cout_d  = cout_new;
        state_d = S_LOAD;
        if (nfc_q > lim_q) begin
          if (cw_q < 4'(MCB)) begin
            cw_d  = cw_up;
            lim_d = CW'((32'd1 << cw_up) - 32'd1);
          end else if (cin_q > nchk_q) begin
            rem_d = '0; quo_d = cx100; dcnt_d = '0; state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, cin_q}) begin
          rem_d = 32'(trial - {1'b0, cin_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = S_RATIO;
        end
      end
      S_RATIO: begin
        if ($signed(quo_q[15:0]) > $signed(prev_q)) begin
          clrp_d = 1'b1; nc_d = 3'd2; cin_d = '0; cout_d = '0;
          prev_d = 16'(lzwvw_pkg::RatioStart);
          nfc_d = CW'(lzwvw_pkg::CodeFirst); cw_d = 4'(lzwvw_pkg::WidthStart);
          lim_d = CW'((32'd1 << lzwvw_pkg::WidthStart) - 32'd1);
          nchk_d = 32'(intv_q);
        end else begin
          prev_d = quo_q[15:0];
          nchk_d = cin_q + 32'(intv_q);
        end
        state_d = S_LOAD;
      end
      S_LOAD: begin
        acc_d   = acc_q | (cval << (6'd32 - {2'b0, ew_q} - fill_q));
        fill_d  = fill_q + {2'b0, ew_q};
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (fill_q >= 6'd8) begin
          if (out_free) begin
            ov_d = 1'b1; ob_d = acc_q[31:24];
            ol_d = (fill_after < 6'd8) && (ek_q + 3'd1 == nc_q);
            od_d = (fill_after < 6'd8) && (ek_q + 3'd1 == nc_q) && fin_q;
            acc_d = acc_q << 8; fill_d = fill_after;
          end
        end else if (ek_q + 3'd1 != nc_q) begin
          if (fin_q && ek_q == 3'd0 && nfc_q == lim_q) begin
            ew_d = ew_q + 4'd1;
          end
          ek_d = ek_q + 3'd1; state_d = S_LOAD;
        end else if (fin_q) begin
          cur_d = '0; nfc_d = CW'(lzwvw_pkg::CodeFirst); cw_d = 4'(lzwvw_pkg::WidthStart);
          lim_d = CW'((32'd1 << lzwvw_pkg::WidthStart) - 32'd1);
          acc_d = '0; fill_d = '0; cin_d = '0; cout_d = '0; nchk_d = 32'(intv_q);
          prev_d = 16'(lzwvw_pkg::RatioStart); first_d = 1'b1;
          clr_d = '0; state_d = S_CLR;
        end else if (clrp_q) begin
          clr_d = '0; state_d = S_CLR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        mem_we = 1'b1; mem_addr = clr_q;
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(HASH_TABLE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; intv_q <= 16'(lzwvw_pkg::IntervalReset); cur_q <= '0;
      nfc_q <= CW'(lzwvw_pkg::CodeFirst); cw_q <= 4'(lzwvw_pkg::WidthStart);
      lim_q <= CW'((32'd1 << lzwvw_pkg::WidthStart) - 32'd1);
      acc_q <= '0; fill_q <= '0; cin_q <= '0; cout_q <= '0;
      nchk_q <= 32'(lzwvw_pkg::IntervalReset); prev_q <= 16'(lzwvw_pkg::RatioStart);
      first_q <= 1'b1; clr_q <= '0; ek_q <= '0; nc_q <= '0; fin_q <= 1'b0;
      clrp_q <= 1'b0; dcnt_q <= '0; ov_q <= 1'b0; n_q <= '0;
    end else begin
      state_q <= state_d; intv_q <= intv_d; cur_q <= cur_d; nfc_q <= nfc_d;
      cw_q <= cw_d; lim_q <= lim_d; acc_q <= acc_d; fill_q <= fill_d;
      cin_q <= cin_d; cout_q <= cout_d; nchk_q <= nchk_d; prev_q <= prev_d;
      first_q <= first_d; clr_q <= clr_d; ek_q <= ek_d; nc_q <= nc_d;
      fin_q <= fin_d; clrp_q <= clrp_d; dcnt_q <= dcnt_d; ov_q <= ov_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ew_q <= ew_d; byte_q <= byte_d; idx_q <= idx_d; step_q <= step_d;
    ecode_q <= ecode_d; rem_q <= rem_d; quo_q <= quo_d;
    ol_q <= ol_d; od_q <= od_d; ob_q <= ob_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ob_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = od_q;
endmodule
`default_nettype wire

@@ design/lzwvw_checker.sv @@
// port-level checks for the variable-width lzw encoder, bound to its top level
// depends on lzw_encoder_variable_width_top
`default_nettype none
module lzwvw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tuser
);
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream end without tlast");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_sweep_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser |=> !s_axis_tready)
    else $error("input taken during dictionary sweep");

  a_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready right after reset");
endmodule

bind lzw_encoder_variable_width_top lzwvw_checker u_lzwvw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
